/* hw/rtl/perlin_noise_3d_macros.svh */
// ---------------------------------------------------------------------------
// perlin_noise_3d assertion macros
// Shorthand for clocked assertions on clk with asynchronous reset arst_n.
// ---------------------------------------------------------------------------
`ifndef PERLIN_NOISE_3D_MACROS_SVH
`define PERLIN_NOISE_3D_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PN_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PN_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pn_pkg.sv */
// ---------------------------------------------------------------------------
// pn_pkg
// Shared constants, types and functions of the 3D gradient noise block.
// ---------------------------------------------------------------------------
`default_nettype none

package pn_pkg;

	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 24;
	localparam int TBL_DEPTH = 256;
	localparam int TBL_AW    = 8;
	localparam int NUM_RD    = 14;
	localparam int NUM_RAM   = NUM_RD / 2;
	localparam int VAL_W     = 19;
	localparam int FADE_W    = 17;

	localparam logic OP_EVAL  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [FADE_W-1:0] fade_t;
	typedef logic [TBL_AW-1:0] tbl_addr_t;

	typedef struct packed {
		logic      we;
		tbl_addr_t idx;
		logic [7:0] val;
	} tbl_wr_t;

	localparam logic [7:0] PERM_RESET [TBL_DEPTH] = '{
		8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
		8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,
		8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,
		8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,
		8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,
		8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,
		8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,
		8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
		8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,
		8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,
		8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,
		8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,
		8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,
		8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,
		8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
		8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,
		8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,
		8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,
		8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,
		8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,
		8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,
		8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
		8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
		8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
	};

	// Fraction of a coordinate as a Q0.16 value.
	function automatic logic [15:0] frac_q16(logic [COORD_W-1:0] c);
		logic [COORD_W+15:0] t;
		t = {c, 16'b0} >> FRAC_BITS;
		return t[15:0];
	endfunction

	// Integer part of a coordinate modulo 256.
	function automatic tbl_addr_t int_part(logic [COORD_W-1:0] c);
		logic [COORD_W-1:0] t;
		t = c >> FRAC_BITS;
		return t[TBL_AW-1:0];
	endfunction

	// Dot product of a cube-edge gradient, picked by the hash, with the offset vector.
	function automatic val_t grad(logic [3:0] h, val_t x, val_t y, val_t z);
		val_t u;
		val_t v;
		u = (h < 4'd8) ? x : y;
		if (h < 4'd4) begin
			v = y;
		end else if (h == 4'd12 || h == 4'd14) begin
			v = x;
		end else begin
			v = z;
		end
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/pn_in_if.sv */
// ---------------------------------------------------------------------------
// pn_in_if
// Request channel: evaluate a point or write one permutation entry.
// ---------------------------------------------------------------------------
`default_nettype none

interface pn_in_if;
	logic        valid;
	logic        ready;
	logic        op;
	logic [23:0] x_coord;
	logic [23:0] y_coord;
	logic [23:0] z_coord;
	logic [7:0]  table_index;
	logic [7:0]  table_value;

	modport source (output valid, op, x_coord, y_coord, z_coord, table_index, table_value,
		input ready);
	modport sink (input valid, op, x_coord, y_coord, z_coord, table_index, table_value,
		output ready);
endinterface

`default_nettype wire

/* hw/rtl/pn_out_if.sv */
// ---------------------------------------------------------------------------
// pn_out_if
// Result channel: one noise sample per evaluate request.
// ---------------------------------------------------------------------------
`default_nettype none

interface pn_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] noise_value;

	modport source (output valid, noise_value, input ready);
	modport sink (input valid, noise_value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pn_ram.sv */
// ---------------------------------------------------------------------------
// pn_ram
// Generic RAM: one write port, two registered read ports with read enable.
// ---------------------------------------------------------------------------
`default_nettype none

module pn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     en,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (en) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/pn_table.sv */
// ---------------------------------------------------------------------------
// pn_table
// Permutation table in replicated dual-read RAMs with per-entry valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

module pn_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pn_pkg::tbl_wr_t   wr,
	input  wire logic              en,
	input  wire pn_pkg::tbl_addr_t raddr [pn_pkg::NUM_RD],
	output logic [7:0]             rdata [pn_pkg::NUM_RD]
);

	logic [pn_pkg::TBL_DEPTH-1:0] vld_q;
	logic                         vld_rq  [pn_pkg::NUM_RD];
	pn_pkg::tbl_addr_t            addr_rq [pn_pkg::NUM_RD];
	logic [7:0]                   ram_q   [pn_pkg::NUM_RD];

	// Every copy takes every write, so all copies stay identical.
	for (genvar k = 0; k < pn_pkg::NUM_RAM; k++) begin : g_ram
		pn_ram #(.WIDTH(8), .DEPTH(pn_pkg::TBL_DEPTH)) u_ram (
			.clk     (clk),
			.we      (wr.we),
			.waddr   (wr.idx),
			.wdata   (wr.val),
			.en      (en),
			.raddr_a (raddr[2*k]),
			.raddr_b (raddr[2*k+1]),
			.rdata_a (ram_q[2*k]),
			.rdata_b (ram_q[2*k+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.we) begin
			vld_q[wr.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < pn_pkg::NUM_RD; k++) begin
				vld_rq[k]  <= 1'b0;
				addr_rq[k] <= '0;
			end
		end else if (en) begin
			for (int k = 0; k < pn_pkg::NUM_RD; k++) begin
				vld_rq[k]  <= vld_q[raddr[k]];
				addr_rq[k] <= raddr[k];
			end
		end
	end

	// An entry never written reads as the reset permutation.
	always_comb begin
		for (int k = 0; k < pn_pkg::NUM_RD; k++) begin
			rdata[k] = vld_rq[k] ? ram_q[k] : pn_pkg::PERM_RESET[addr_rq[k]];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/pn_fade.sv */
// ---------------------------------------------------------------------------
// pn_fade
// Four-stage pipelined quintic fade 6t^5 - 15t^4 + 10t^3 in Q16.
// ---------------------------------------------------------------------------
`default_nettype none

module pn_fade (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [15:0] n,
	output pn_pkg::fade_t    fade
);

	logic [15:0] n_s2;
	logic [31:0] sq_s2;
	logic [19:0] s16_s3;
	logic [31:0] m_s3;
	logic [35:0] f_s4;
	logic [37:0] poly;
	logic [15:0] n2;
	logic [15:0] n3;

	always_comb begin
		n2   = sq_s2[31:16];
		poly = 38'd6 * {6'd0, sq_s2} + (38'd10 << 32) - ((38'd15 * {22'd0, n_s2}) << 16);
		n3   = m_s3[31:16];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2   <= n;
			sq_s2  <= n * n;
			s16_s3 <= poly[35:16];
			m_s3   <= n2 * n_s2;
			f_s4   <= n3 * s16_s3;
			fade   <= (f_s4[35:16] > 20'd65536) ? pn_pkg::FADE_W'(65536) : f_s4[32:16];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/pn_lerp.sv */
// ---------------------------------------------------------------------------
// pn_lerp
// Three-stage linear blend a + floor(t * (b - a) / 2^16).
// ---------------------------------------------------------------------------
`default_nettype none

module pn_lerp (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire pn_pkg::fade_t t,
	input  wire pn_pkg::val_t  a,
	input  wire pn_pkg::val_t  b,
	output pn_pkg::val_t       r
);

	logic signed [pn_pkg::VAL_W:0]    d_s1;
	pn_pkg::val_t                     a_s1;
	pn_pkg::fade_t                    t_s1;
	logic signed [pn_pkg::VAL_W+18:0] p_s2;
	pn_pkg::val_t                     a_s2;
	logic signed [pn_pkg::VAL_W+18:0] sh;

	assign sh = p_s2 >>> 16;

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= {b[pn_pkg::VAL_W-1], b} - {a[pn_pkg::VAL_W-1], a};
			a_s1 <= a;
			t_s1 <= t;
			p_s2 <= $signed({1'b0, t_s1}) * d_s1;
			a_s2 <= a_s1;
			r    <= a_s2 + sh[pn_pkg::VAL_W-1:0];
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/perlin_noise_3d.sv */
// ---------------------------------------------------------------------------
// perlin_noise_3d
// Fixed-point 3D improved gradient noise with a writable permutation table.
// ---------------------------------------------------------------------------
// Takes one request per clock unless held; the whole pipeline holds while
// the result register is full and not taken. The permutation table lives
// in seven identical dual-read RAM copies, so the fourteen lookups of one
// point are spread over three pipeline stages with no sharing. A table
// write request is accepted only when no evaluate is in those three lookup
// stages, so it waits behind earlier points until they leave those stages,
// and longer while the result side stalls and those stages are held.
// Reset restores the reference permutation at once through per-entry valid
// bits; there is no clearing pass.
`default_nettype none

`include "perlin_noise_3d_macros.svh"

module perlin_noise_3d (
	input  wire logic clk,
	input  wire logic arst_n,
	pn_in_if.sink     sample,
	pn_out_if.source  result
);

	localparam int NSTG = 14;

	logic adv;
	logic lookup_busy;
	logic acc_eval;
	logic acc_write;

	logic [NSTG:1] stg_vld_q;
	logic          out_valid_q;
	logic [15:0]   noise_q;

	pn_pkg::tbl_addr_t xi_s1, yi_s1, zi_s1, yi_s2, zi_s2, zi_s3;
	logic [15:0] nx_s1, ny_s1, nz_s1;
	logic [15:0] nx_s2, ny_s2, nz_s2;
	logic [15:0] nx_s3, ny_s3, nz_s3;
	logic [15:0] nx_s4, ny_s4, nz_s4;

	pn_pkg::tbl_wr_t   tbl_wr;
	pn_pkg::tbl_addr_t raddr [pn_pkg::NUM_RD];
	logic [7:0]        rdata [pn_pkg::NUM_RD];

	pn_pkg::tbl_addr_t ha, hb, haa, hab, hba, hbb;
	pn_pkg::val_t      px, py, pz, px1, py1, pz1;
	pn_pkg::val_t      g_s5 [8];
	pn_pkg::fade_t     fu_s5, fv_s5, fw_s5;
	pn_pkg::fade_t     fv_d [3];
	pn_pkg::fade_t     fw_d [6];
	pn_pkg::val_t      l1 [4];
	pn_pkg::val_t      l2 [2];
	pn_pkg::val_t      res;
	logic signed [pn_pkg::VAL_W:0] o_sum;
	logic [15:0]       noise_d;

	assign adv         = !out_valid_q || result.ready;
	assign lookup_busy = stg_vld_q[1] || stg_vld_q[2] || stg_vld_q[3];
	assign sample.ready = (sample.op == pn_pkg::OP_EVAL) ? adv : !lookup_busy;
	assign acc_eval    = sample.valid && sample.ready && (sample.op == pn_pkg::OP_EVAL);
	assign acc_write   = sample.valid && sample.ready && (sample.op == pn_pkg::OP_WRITE);

	assign tbl_wr.we  = acc_write;
	assign tbl_wr.idx = sample.table_index;
	assign tbl_wr.val = sample.table_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			stg_vld_q   <= {stg_vld_q[NSTG-1:1], acc_eval};
			out_valid_q <= stg_vld_q[NSTG];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xi_s1 <= pn_pkg::int_part(sample.x_coord);
			yi_s1 <= pn_pkg::int_part(sample.y_coord);
			zi_s1 <= pn_pkg::int_part(sample.z_coord);
			nx_s1 <= pn_pkg::frac_q16(sample.x_coord);
			ny_s1 <= pn_pkg::frac_q16(sample.y_coord);
			nz_s1 <= pn_pkg::frac_q16(sample.z_coord);
			yi_s2 <= yi_s1;
			zi_s2 <= zi_s1;
			zi_s3 <= zi_s2;
			{nx_s2, ny_s2, nz_s2} <= {nx_s1, ny_s1, nz_s1};
			{nx_s3, ny_s3, nz_s3} <= {nx_s2, ny_s2, nz_s2};
			{nx_s4, ny_s4, nz_s4} <= {nx_s3, ny_s3, nz_s3};
		end
	end

	// Lookup chain: x corners in stage 1, x/y in stage 2, all eight corners in stage 3.
	always_comb begin
		ha  = rdata[0] + yi_s2;
		hb  = rdata[1] + yi_s2;
		haa = rdata[2] + zi_s3;
		hab = rdata[3] + zi_s3;
		hba = rdata[4] + zi_s3;
		hbb = rdata[5] + zi_s3;
		raddr[0]  = xi_s1;
		raddr[1]  = xi_s1 + 8'd1;
		raddr[2]  = ha;
		raddr[3]  = ha + 8'd1;
		raddr[4]  = hb;
		raddr[5]  = hb + 8'd1;
		raddr[6]  = haa;
		raddr[7]  = haa + 8'd1;
		raddr[8]  = hab;
		raddr[9]  = hab + 8'd1;
		raddr[10] = hba;
		raddr[11] = hba + 8'd1;
		raddr[12] = hbb;
		raddr[13] = hbb + 8'd1;
	end

	pn_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (tbl_wr),
		.en     (adv),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	always_comb begin
		px  = pn_pkg::val_t'({3'b000, nx_s4});
		py  = pn_pkg::val_t'({3'b000, ny_s4});
		pz  = pn_pkg::val_t'({3'b000, nz_s4});
		px1 = px - pn_pkg::val_t'(65536);
		py1 = py - pn_pkg::val_t'(65536);
		pz1 = pz - pn_pkg::val_t'(65536);
	end

	// Hash order per port: aa, aa+1, ab, ab+1, ba, ba+1, bb, bb+1.
	always_ff @(posedge clk) begin
		if (adv) begin
			g_s5[0] <= pn_pkg::grad(rdata[6][3:0],  px,  py,  pz);
			g_s5[1] <= pn_pkg::grad(rdata[10][3:0], px1, py,  pz);
			g_s5[2] <= pn_pkg::grad(rdata[8][3:0],  px,  py1, pz);
			g_s5[3] <= pn_pkg::grad(rdata[12][3:0], px1, py1, pz);
			g_s5[4] <= pn_pkg::grad(rdata[7][3:0],  px,  py,  pz1);
			g_s5[5] <= pn_pkg::grad(rdata[11][3:0], px1, py,  pz1);
			g_s5[6] <= pn_pkg::grad(rdata[9][3:0],  px,  py1, pz1);
			g_s5[7] <= pn_pkg::grad(rdata[13][3:0], px1, py1, pz1);
		end
	end

	pn_fade u_fade_x (.clk(clk), .en(adv), .n(nx_s1), .fade(fu_s5));
	pn_fade u_fade_y (.clk(clk), .en(adv), .n(ny_s1), .fade(fv_s5));
	pn_fade u_fade_z (.clk(clk), .en(adv), .n(nz_s1), .fade(fw_s5));

	always_ff @(posedge clk) begin
		if (adv) begin
			fv_d[0] <= fv_s5;
			fw_d[0] <= fw_s5;
			for (int k = 1; k < 3; k++) begin
				fv_d[k] <= fv_d[k-1];
			end
			for (int k = 1; k < 6; k++) begin
				fw_d[k] <= fw_d[k-1];
			end
		end
	end

	for (genvar k = 0; k < 4; k++) begin : g_lerp_x
		pn_lerp u_lerp (.clk(clk), .en(adv), .t(fu_s5), .a(g_s5[2*k]), .b(g_s5[2*k+1]),
			.r(l1[k]));
	end

	for (genvar k = 0; k < 2; k++) begin : g_lerp_y
		pn_lerp u_lerp (.clk(clk), .en(adv), .t(fv_d[2]), .a(l1[2*k]), .b(l1[2*k+1]),
			.r(l2[k]));
	end

	pn_lerp u_lerp_z (.clk(clk), .en(adv), .t(fw_d[5]), .a(l2[0]), .b(l2[1]), .r(res));

	// Map -1..1 to 0..1 and saturate at both ends.
	always_comb begin
		o_sum = {res[pn_pkg::VAL_W-1], res} + (pn_pkg::VAL_W+1)'(65536);
		if (o_sum < 0) begin
			noise_d = 16'd0;
		end else if (o_sum[pn_pkg::VAL_W-1:1] > (pn_pkg::VAL_W-1)'(65535)) begin
			noise_d = 16'hFFFF;
		end else begin
			noise_d = o_sum[16:1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			noise_q <= noise_d;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.noise_value = noise_q;

	`PN_ASSERT_SAME(a_write_no_lookup, acc_write, !lookup_busy,
		"table write accepted while an evaluate is still reading the table")
	`PN_ASSERT_NEXT(a_eval_enters, acc_eval, stg_vld_q[1],
		"accepted evaluate request did not enter the pipeline")
	`PN_ASSERT_NEXT(a_last_to_out, stg_vld_q[NSTG] && adv, out_valid_q,
		"finished evaluate did not reach the result register")

endmodule

`default_nettype wire
